FILE: rtl/pprp_pkg.sv
// Shared types and constants for the ping-pong receive read planner.
package pprp_pkg;

  // Half and local buffer geometry, in bytes.
  localparam int HALF_BYTES  = 8192;
  localparam int LOCAL_BYTES = 4096;
  localparam int CYCLE_BYTES = 2 * HALF_BYTES;

  // Read offset width and width of a clamped read length.
  localparam int OFF_W = $clog2(CYCLE_BYTES);
  localparam int CNT_W = $clog2(LOCAL_BYTES + 1);

  // Field widths of the receiver register words.
  localparam int PTR_W  = 15;
  localparam int LEN_W  = 14;
  localparam int ADDR_W = 14;
  localparam int MODE_W = 2;

  // Receiver state codes.
  localparam logic [MODE_W-1:0] MODE_IDLE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LISTEN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OVERFLOW = 2'd2;

  // One snapshot of the receiver registers.
  typedef struct packed {
    logic [PTR_W-1:0]  rx_ptr;
    logic [LEN_W-1:0]  rx_len;
    logic [PTR_W-1:0]  alt_ptr;
    logic [LEN_W-1:0]  alt_len;
    logic [MODE_W-1:0] rx_mode;
  } rx_snap_t;

  // One read plan with the register words to write back.
  typedef struct packed {
    logic [ADDR_W-1:0] first_read_addr;
    logic [LEN_W-1:0]  first_read_len;
    logic [ADDR_W-1:0] second_read_addr;
    logic [LEN_W-1:0]  second_read_len;
    logic              rewrite_all;
    logic              rewrite_alt;
    logic              link_alive;
    logic [PTR_W-1:0]  new_ptr;
    logic [LEN_W-1:0]  new_len;
    logic [PTR_W-1:0]  new_alt_ptr;
    logic [LEN_W-1:0]  new_alt_len;
    logic [MODE_W-1:0] new_mode;
  } rd_plan_t;

endpackage

FILE: rtl/pprp_chan_if.sv
// Valid/ready channel carrying one word of a given payload type.
interface pprp_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/pingpong_rx_read_planner.sv
// Top level of the ping-pong receive read planner.
//
// The planner sits on the consumer side of a receive memory split into two
// halves of HALF_BYTES each. Every word taken on the snap channel is one
// snapshot of the receiver's pointer, length, alternate pointer, alternate
// length and state; for each snapshot exactly one word leaves on the plan
// channel. That word describes up to two reads, the first in the half that
// holds the block's own read offset and the second from the base of the
// opposite half once the receiver has flipped, together clamped to
// LOCAL_BYTES, and the register words the driver should write back. The read
// offset advances by the total planned and wraps at twice HALF_BYTES. A
// snapshot in the idle state clears the offset and asks for a full
// initialisation of both halves; once nothing unread remains, an overflow
// snapshot asks for a flip to the free half and otherwise the alternate
// half is re-armed if none is armed. The block accepts one word every clock
// cycle while the plan channel does not stall it. A word is held in the
// input register and the plan is computed in a single pass from there into
// the result register, from which it is offered on the plan channel. The
// input register refills while a finished plan waits to be taken, and
// back-pressure from the plan channel stalls only the words behind it.
// There is no start-up sweep: the planner is ready straight after reset.
module pingpong_rx_read_planner
  import pprp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  pprp_chan_if.sink    snap,
  pprp_chan_if.source  plan
);

  // Input register.
  rx_snap_t snap_q;
  logic     snap_vld;

  // Result register.
  rd_plan_t plan_q;
  logic     plan_vld;

  // Consumed bytes, modulo twice the half size.
  logic [OFF_W-1:0] read_offset;
  logic [OFF_W-1:0] read_offset_next;

  rd_plan_t plan_next;

  // The held snapshot moves on whenever the result register is free or
  // is being emptied in this cycle.
  logic advance;
  assign advance    = snap_vld && (!plan_vld || plan.ready);
  assign snap.ready = !snap_vld || advance;

  assign plan.valid = plan_vld;
  assign plan.data  = plan_q;

  // Planning logic.
  logic [PTR_W:0]   end_p;
  logic [PTR_W:0]   end_a;
  logic             rh;
  logic [OFF_W-1:0] rho;
  logic [31:0]      rbase;
  logic [31:0]      obase;
  logic [31:0]      rl_raw;
  logic [31:0]      rf_raw;
  logic [32:0]      raw_sum;
  logic [CNT_W-1:0] rl;
  logic [CNT_W-1:0] rf;
  logic [CNT_W:0]   total;
  logic [OFF_W:0]   off_sum;
  logic             unread;
  logic [PTR_W-1:0] nbase;

  always_comb begin
    end_p = {1'b0, snap_q.rx_ptr} + (PTR_W + 1)'(snap_q.rx_len);
    end_a = {1'b0, snap_q.alt_ptr} + (PTR_W + 1)'(snap_q.alt_len);

    // Which half the offset lies in, and the offset within it.
    rh    = read_offset >= OFF_W'(HALF_BYTES);
    rho   = rh ? (read_offset - OFF_W'(HALF_BYTES)) : read_offset;
    rbase = rh ? 32'(HALF_BYTES) : 32'd0;
    obase = rh ? 32'd0 : 32'(HALF_BYTES);

    // With no alternate half armed the receiver has flipped: the rest of
    // this half is unread and the opposite half holds data up to the
    // pointer. Otherwise the data end at the pointer in this half.
    // Everything wraps at 32 bits so that inconsistent snapshots still
    // give a defined, clamped plan.
    if (end_a == '0) begin
      rl_raw = 32'(HALF_BYTES) - 32'(rho);
      rf_raw = 32'(snap_q.rx_ptr) - obase;
    end else begin
      rl_raw = 32'(snap_q.rx_ptr) - rbase - 32'(rho);
      rf_raw = 32'd0;
    end
    raw_sum = {1'b0, rl_raw} + {1'b0, rf_raw};

    // Clamp the two reads to the local buffer, the first read first.
    if (rl_raw > 32'(LOCAL_BYTES)) begin
      rl = CNT_W'(LOCAL_BYTES);
      rf = '0;
    end else if (raw_sum > 33'(LOCAL_BYTES)) begin
      rl = CNT_W'(rl_raw);
      rf = CNT_W'(32'(LOCAL_BYTES) - rl_raw);
    end else begin
      rl = CNT_W'(rl_raw);
      rf = CNT_W'(rf_raw);
    end

    // The total never exceeds the local buffer, which is smaller than the
    // ring, so one conditional subtraction does the wrap.
    total   = (CNT_W + 1)'(rl) + (CNT_W + 1)'(rf);
    off_sum = (OFF_W + 1)'(read_offset) + (OFF_W + 1)'(total);
    if (off_sum >= (OFF_W + 1)'(CYCLE_BYTES)) begin
      read_offset_next = OFF_W'(off_sum - (OFF_W + 1)'(CYCLE_BYTES));
    end else begin
      read_offset_next = OFF_W'(off_sum);
    end

    // Data are still unread when the receiver fills the half opposite the one
    // that the offset now points into.
    unread = (read_offset_next <  OFF_W'(HALF_BYTES) && end_p == (PTR_W + 1)'(CYCLE_BYTES))
          || (read_offset_next >= OFF_W'(HALF_BYTES) && end_p == (PTR_W + 1)'(HALF_BYTES));
    nbase  = (end_p == (PTR_W + 1)'(CYCLE_BYTES)) ? '0 : PTR_W'(HALF_BYTES);

    plan_next.first_read_addr  = ADDR_W'(read_offset);
    plan_next.first_read_len   = LEN_W'(rl);
    plan_next.second_read_addr = ADDR_W'(obase);
    plan_next.second_read_len  = LEN_W'(rf);
    plan_next.rewrite_all      = 1'b0;
    plan_next.rewrite_alt      = 1'b0;
    plan_next.link_alive       = 1'b1;
    plan_next.new_ptr          = snap_q.rx_ptr;
    plan_next.new_len          = snap_q.rx_len;
    plan_next.new_alt_ptr      = snap_q.alt_ptr;
    plan_next.new_alt_len      = snap_q.alt_len;
    plan_next.new_mode         = snap_q.rx_mode;

    if (!unread) begin
      if (snap_q.rx_mode == MODE_OVERFLOW) begin
        // Recover by flipping to the free half with nothing armed behind it.
        plan_next.new_ptr     = nbase;
        plan_next.new_len     = LEN_W'(HALF_BYTES);
        plan_next.new_alt_ptr = '0;
        plan_next.new_alt_len = '0;
        plan_next.new_mode    = MODE_LISTEN;
        plan_next.rewrite_all = 1'b1;
      end else if (end_a == '0) begin
        // Re-arm the alternate half.
        plan_next.new_alt_ptr = nbase;
        plan_next.new_alt_len = LEN_W'(HALF_BYTES);
        plan_next.rewrite_alt = 1'b1;
      end
    end

    // Idle: initialise both halves and start reading from the beginning.
    if (snap_q.rx_mode == MODE_IDLE) begin
      read_offset_next           = '0;
      plan_next.first_read_addr  = '0;
      plan_next.first_read_len   = '0;
      plan_next.second_read_addr = '0;
      plan_next.second_read_len  = '0;
      plan_next.rewrite_all      = 1'b1;
      plan_next.rewrite_alt      = 1'b0;
      plan_next.link_alive       = 1'b0;
      plan_next.new_ptr          = '0;
      plan_next.new_len          = LEN_W'(HALF_BYTES);
      plan_next.new_alt_ptr      = PTR_W'(HALF_BYTES);
      plan_next.new_alt_len      = LEN_W'(HALF_BYTES);
      plan_next.new_mode         = MODE_LISTEN;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_vld    <= 1'b0;
      plan_vld    <= 1'b0;
      read_offset <= '0;
    end else begin
      if (snap.ready) begin
        snap_vld <= snap.valid;
      end
      if (advance) begin
        plan_vld    <= 1'b1;
        read_offset <= read_offset_next;
      end else if (plan.ready) begin
        plan_vld <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (snap.ready && snap.valid) begin
      snap_q <= snap.data;
    end
    if (advance) begin
      plan_q <= plan_next;
    end
  end

endmodule
